[hdl/avr_pkg.sv]
// Shared types, codes and constants of the ADSR voice waveform renderer.
package avr_pkg;

    localparam int FRAME_SAMPLES_DEF = 32;
    localparam int VOICE_COUNT_DEF   = 16;

    localparam int LEVEL_W    = 15;
    localparam int FREQ_W     = 15;
    localparam int RATE_W     = 17;
    localparam int PHASE_W    = 24;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7FFF;

    // Operation codes of an input item.
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_RENDER   = 2'd2;

    // Waveform codes.
    localparam logic [1:0] WAVE_SQUARE   = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [1:0] WAVE_SINE     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_PEAK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd5;

    // Shared divider sizes and the quotient lengths of each division.
    localparam int DIV_N_W = 44;
    localparam int DIV_D_W = 18;
    localparam int DIV_R_W = 19;
    localparam int DIV_C_W = 6;

    localparam logic [DIV_C_W-1:0] CNT_PHASE  = 6'd44;
    localparam logic [DIV_C_W-1:0] CNT_STEP   = 6'd20;
    localparam logic [DIV_C_W-1:0] CNT_PERIOD = 6'd17;
    localparam logic [DIV_C_W-1:0] CNT_MOD    = 6'd24;
    localparam logic [DIV_C_W-1:0] CNT_SCALE  = 6'd16;

    typedef enum logic [2:0] {
        ENV_IDLE    = 3'd0,
        ENV_ATTACK  = 3'd1,
        ENV_DECAY   = 3'd2,
        ENV_SUSTAIN = 3'd3,
        ENV_RELEASE = 3'd4
    } env_phase_t;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_SIN_MUL,
        SEQ_SIN_DIV0,
        SEQ_SIN_WAIT0,
        SEQ_SIN_DIV1,
        SEQ_SIN_WAIT1,
        SEQ_TRI_DIVP,
        SEQ_TRI_WAITP,
        SEQ_TRI_DIVM,
        SEQ_TRI_WAITM,
        SEQ_TRI_MULM,
        SEQ_SMP_SIN_MUL,
        SEQ_SMP_SIN_RND,
        SEQ_SMP_TRI_MUL,
        SEQ_SMP_TRI_DIV,
        SEQ_SMP_TRI_WAIT,
        SEQ_EMIT
    } seq_state_t;

    typedef struct packed {
        logic note_on;
        logic note_off;
        logic step;
    } env_cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_peak;
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] release_step;
    } env_cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done;
    } env_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
        logic [DIV_C_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_R_W-1:0] remainder;
    } div_rsp_t;

    // One period of a sine, round(32767 * sin(2*pi*i/32)).
    localparam logic signed [SAMPLE_W-1:0] SINE_ROM [32] = '{
        16'sd0,      16'sd6393,   16'sd12539,  16'sd18204,
        16'sd23170,  16'sd27245,  16'sd30273,  16'sd32137,
        16'sd32767,  16'sd32137,  16'sd30273,  16'sd27245,
        16'sd23170,  16'sd18204,  16'sd12539,  16'sd6393,
        16'sd0,      -16'sd6393,  -16'sd12539, -16'sd18204,
        -16'sd23170, -16'sd27245, -16'sd30273, -16'sd32137,
        -16'sd32767, -16'sd32137, -16'sd30273, -16'sd27245,
        -16'sd23170, -16'sd18204, -16'sd12539, -16'sd6393
    };

endpackage

[hdl/avr_if.sv]
// Handshake channel interfaces: input items, result samples and configuration writes.
interface avr_in_if;
    import avr_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [3:0]          voice;
    logic [1:0]          wave;
    logic [FREQ_W-1:0]   freq;
    logic [PHASE_W-1:0]  phase_start;

    modport source (output valid, output op, output voice, output wave, output freq,
                    output phase_start, input ready);
    modport sink (input valid, input op, input voice, input wave, input freq,
                  input phase_start, output ready);
endinterface

interface avr_out_if;
    import avr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       voice_done;

    modport source (output valid, output sample, output last, output voice_done,
                    input ready);
    modport sink (input valid, input sample, input last, input voice_done, output ready);
endinterface

interface avr_cfg_if;
    import avr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/avr_env.sv]
// Per-voice ADSR envelope state and the single envelope step.
module avr_env #(
    parameter int VOICE_COUNT = avr_pkg::VOICE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        voice,
    input  avr_pkg::env_cmd_t cmd,
    input  avr_pkg::env_cfg_t cfg,
    output avr_pkg::env_rsp_t rsp
);
    import avr_pkg::*;

    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    env_phase_t         phase_reg [VOICE_COUNT];
    logic [LEVEL_W-1:0] level_reg [VOICE_COUNT];

    logic [VIDX_W+3:0]  voice_wide;
    logic [VIDX_W-1:0]  vidx;
    logic               in_range;
    env_phase_t         phase_cur;
    logic [LEVEL_W-1:0] level_cur;
    env_phase_t         phase_step;
    logic [LEVEL_W-1:0] level_step;
    logic               done_step;
    logic [LEVEL_W:0]   attack_sum;

    assign voice_wide = {{VIDX_W{1'b0}}, voice};
    assign vidx       = voice_wide[VIDX_W-1:0];
    assign in_range   = {28'd0, voice} < 32'(VOICE_COUNT);
    assign phase_cur  = phase_reg[vidx];
    assign level_cur  = level_reg[vidx];
    assign attack_sum = {1'b0, level_cur} + {1'b0, cfg.attack_step};

    // Attack may hand over to decay within the same step, as may decay to sustain.
    always_comb
    begin
        phase_step = phase_cur;
        level_step = level_cur;
        done_step  = 1'b0;
        if (phase_step == ENV_ATTACK)
        begin
            if (level_step < cfg.attack_peak)
                level_step = attack_sum[LEVEL_W] ? LEVEL_MAX : attack_sum[LEVEL_W-1:0];
            else
                phase_step = ENV_DECAY;
        end
        if (phase_step == ENV_DECAY)
        begin
            if (level_step > cfg.sustain_level)
                level_step = (level_step > cfg.decay_step) ?
                             level_step - cfg.decay_step : '0;
            else
            begin
                level_step = cfg.sustain_level;
                phase_step = ENV_SUSTAIN;
            end
        end
        if (phase_step == ENV_RELEASE)
        begin
            if (level_step != '0)
                level_step = (level_step > cfg.release_step) ?
                             level_step - cfg.release_step : '0;
            else
            begin
                phase_step = ENV_IDLE;
                done_step  = 1'b1;
            end
        end
    end

    assign rsp.level = in_range ? level_step : '0;
    assign rsp.done  = in_range && done_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                phase_reg[i] <= ENV_IDLE;
                level_reg[i] <= '0;
            end
        end
        else if (in_range)
        begin
            if (cmd.note_on)
                phase_reg[vidx] <= ENV_ATTACK;
            else if (cmd.note_off && phase_cur != ENV_IDLE)
                phase_reg[vidx] <= ENV_RELEASE;
            else if (cmd.step)
            begin
                phase_reg[vidx] <= phase_step;
                level_reg[vidx] <= level_step;
            end
        end
    end

endmodule

[hdl/avr_div.sv]
// Shared restoring divider that produces one quotient bit per cycle.
module avr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  avr_pkg::div_req_t req,
    output avr_pkg::div_rsp_t rsp
);
    import avr_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic [DIV_R_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] acc_reg;
    logic [DIV_D_W-1:0] div_reg;

    logic [DIV_R_W-1:0] load_rem;
    logic [DIV_N_W-1:0] load_acc;
    logic [DIV_R_W-1:0] rem_shift;
    logic               ge;
    logic [DIV_R_W-1:0] rem_next;

    // The high part above the quotient length seeds the partial remainder; the caller
    // guarantees that the quotient fits in the requested number of bits.
    assign load_rem  = DIV_R_W'(req.dividend >> req.count);
    assign load_acc  = req.dividend << (DIV_C_W'(DIV_N_W) - req.count);
    assign rem_shift = {rem_reg[DIV_R_W-2:0], acc_reg[DIV_N_W-1]};
    assign ge        = rem_shift >= {1'b0, div_reg};
    assign rem_next  = ge ? rem_shift - {1'b0, div_reg} : rem_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.count;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_C_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= load_rem;
            acc_reg <= load_acc;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            acc_reg <= {acc_reg[DIV_N_W-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = acc_reg;
    assign rsp.remainder = rem_reg;

endmodule

[hdl/adsr_voice_waveform_renderer.sv]
// Top level: configuration registers, render sequencer, datapath and output register.
//
// Usage. Items arrive on the items channel and are accepted when valid and ready
// are both high. A note_on or note_off request produces no
// result. A render request steps the voice's envelope once and then delivers
// FRAME_SAMPLES results on the results channel, the last flagged by last. While a
// render is in progress items.ready is low; it rises again as soon as the final
// sample has been placed in the output register, so the next request may be taken
// while that sample still waits for the receiver.
// Per render: for square and sine, a 44-bit and a 20-bit division on the shared
// divider set up the phase accumulator; for triangle and sawtooth, every sample
// needs a 16-bit division by twice the sample rate on the same divider.
// The cfg channel is always ready; writes must be made between requests.
// The block itself does not enforce this.
// Reset returns all voices to idle at level zero and loads the default settings.
// A stalled receiver holds the output register and the sequencer waits with it.
module adsr_voice_waveform_renderer #(
    parameter int FRAME_SAMPLES = avr_pkg::FRAME_SAMPLES_DEF,
    parameter int VOICE_COUNT   = avr_pkg::VOICE_COUNT_DEF
) (
    input logic      clk,
    input logic      rst_n,
    avr_in_if.sink   items,
    avr_out_if.source results,
    avr_cfg_if.sink  cfg
);
    import avr_pkg::*;

    localparam int K_W = $clog2(FRAME_SAMPLES);

    seq_state_t state_reg, state_next;

    // Configuration.
    logic [LEVEL_W-1:0] peak_reg, astep_reg, sus_reg, dstep_reg, rstep_reg;
    logic [RATE_W-1:0]  fs_reg;
    logic [RATE_W-1:0]  fs_eff;

    // Request and per-frame state.
    logic [1:0]          wave_reg;
    logic [FREQ_W-1:0]   f_reg;
    logic [PHASE_W-1:0]  start_reg;
    logic [LEVEL_W-1:0]  lv_reg;
    logic                done_reg;
    logic [K_W-1:0]      k_reg;
    logic signed [41:0]  mul_reg;
    logic [4:0]          q5_reg, qinc_reg;
    logic [RATE_W-1:0]   r_reg, rinc_reg;
    logic [17:0]         period_reg, m_reg;
    logic [RATE_W-1:0]   mf_reg;
    logic [SAMPLE_W-1:0] samp_reg;

    // Output register.
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_last_reg;
    logic                out_done_reg;

    logic      in_fire;
    logic      out_free;
    logic      is_sin;
    logic      is_last;
    env_cmd_t  env_cmd;
    env_cfg_t  env_cfg;
    env_rsp_t  env_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    logic signed [25:0]         mul_a;
    logic signed [15:0]         mul_b;
    logic signed [41:0]         prod;
    logic signed [SAMPLE_W-1:0] sine_val;
    logic signed [19:0]         d_tri, d_abs, num;
    logic [DIV_N_W-1:0]         scale_dividend;
    logic [41:0]                rnd_sum;
    logic [SAMPLE_W-1:0]        samp_sin;
    logic [RATE_W:0]            r_sum;
    logic                       r_carry;
    logic [17:0]                m_inc;
    logic                       m_wrap;

    assign fs_eff   = (fs_reg == '0) ? RATE_W'(1) : fs_reg;
    assign in_fire  = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign is_sin   = (wave_reg == WAVE_SQUARE) || (wave_reg == WAVE_SINE);
    assign is_last  = k_reg == K_W'(FRAME_SAMPLES - 1);

    assign items.ready        = state_reg == SEQ_IDLE;
    assign cfg.ready          = 1'b1;
    assign results.valid      = out_valid_reg;
    assign results.sample     = out_sample_reg;
    assign results.last       = out_last_reg;
    assign results.voice_done = out_done_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= 15'd32767;
            astep_reg <= 15'd512;
            sus_reg   <= 15'd16384;
            dstep_reg <= 15'd256;
            rstep_reg <= 15'd256;
            fs_reg    <= 17'd48000;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ATTACK_PEAK:   peak_reg  <= cfg.data[LEVEL_W-1:0];
                CFG_ATTACK_STEP:   astep_reg <= cfg.data[LEVEL_W-1:0];
                CFG_SUSTAIN_LEVEL: sus_reg   <= cfg.data[LEVEL_W-1:0];
                CFG_DECAY_STEP:    dstep_reg <= cfg.data[LEVEL_W-1:0];
                CFG_RELEASE_STEP:  rstep_reg <= cfg.data[LEVEL_W-1:0];
                CFG_SAMPLE_RATE:   fs_reg    <= cfg.data[RATE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign env_cfg.attack_peak   = peak_reg;
    assign env_cfg.attack_step   = astep_reg;
    assign env_cfg.sustain_level = sus_reg;
    assign env_cfg.decay_step    = dstep_reg;
    assign env_cfg.release_step  = rstep_reg;

    assign env_cmd.note_on  = in_fire && (items.op == OP_NOTE_ON);
    assign env_cmd.note_off = in_fire && (items.op == OP_NOTE_OFF);
    assign env_cmd.step     = in_fire && (items.op == OP_RENDER);

    avr_env #(
        .VOICE_COUNT(VOICE_COUNT)
    ) u_env (
        .clk   (clk),
        .rst_n (rst_n),
        .voice (items.voice),
        .cmd   (env_cmd),
        .cfg   (env_cfg),
        .rsp   (env_rsp)
    );

    avr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Waveform arithmetic around the shared multiplier.
    assign sine_val = SINE_ROM[q5_reg];
    assign d_tri    = {1'b0, mf_reg, 2'b00} - {2'b00, fs_eff, 1'b0};
    assign d_abs    = d_tri[19] ? -d_tri : d_tri;
    assign num      = (wave_reg == WAVE_TRIANGLE) ? d_abs - {3'b000, fs_eff}
                                                  : {2'b00, mf_reg, 1'b0} - {3'b000, fs_eff};

    // Offsetting by 65536 times the sample rate keeps the dividend positive; the
    // quotient is then the rounded sample plus 32768.
    assign scale_dividend = {mul_reg[41], mul_reg, 1'b0} + {11'd0, fs_eff, 16'd0}
                          + {27'd0, fs_eff};

    assign rnd_sum  = mul_reg + 42'sd16384;
    assign samp_sin = (wave_reg == WAVE_SQUARE) ?
                      (sine_val[SAMPLE_W-1] ? 16'd0 - {1'b0, lv_reg} : {1'b0, lv_reg}) :
                      rnd_sum[30:15];

    assign r_sum   = {1'b0, r_reg} + {1'b0, rinc_reg};
    assign r_carry = r_sum >= {1'b0, fs_eff};
    assign m_inc   = m_reg + 18'd1;
    assign m_wrap  = m_inc == period_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            SEQ_SIN_MUL:
            begin
                mul_a = {2'b00, start_reg};
                mul_b = {1'b0, f_reg};
            end
            SEQ_TRI_MULM:
            begin
                mul_a = {8'd0, m_reg};
                mul_b = {1'b0, f_reg};
            end
            SEQ_SMP_SIN_MUL:
            begin
                mul_a = {{10{sine_val[SAMPLE_W-1]}}, sine_val};
                mul_b = {1'b0, lv_reg};
            end
            SEQ_SMP_TRI_MUL:
            begin
                mul_a = {{6{num[19]}}, num};
                mul_b = {1'b0, lv_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Sequencer: next state and divider requests.
    always_comb
    begin
        state_next = state_reg;
        div_req    = '0;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_fire && items.op == OP_RENDER)
                begin
                    if (items.wave == WAVE_SQUARE || items.wave == WAVE_SINE)
                        state_next = SEQ_SIN_MUL;
                    else
                        state_next = SEQ_TRI_DIVP;
                end
            end
            SEQ_SIN_MUL:
                state_next = SEQ_SIN_DIV0;
            SEQ_SIN_DIV0:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_reg[38:0], 5'd0};
                div_req.divisor  = {1'b0, fs_eff};
                div_req.count    = CNT_PHASE;
                state_next       = SEQ_SIN_WAIT0;
            end
            SEQ_SIN_WAIT0:
                if (div_rsp.done)
                    state_next = SEQ_SIN_DIV1;
            SEQ_SIN_DIV1:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {24'd0, f_reg, 5'd0};
                div_req.divisor  = {1'b0, fs_eff};
                div_req.count    = CNT_STEP;
                state_next       = SEQ_SIN_WAIT1;
            end
            SEQ_SIN_WAIT1:
                if (div_rsp.done)
                    state_next = SEQ_SMP_SIN_MUL;
            SEQ_TRI_DIVP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {27'd0, fs_eff};
                div_req.divisor  = {3'd0, f_reg};
                div_req.count    = CNT_PERIOD;
                state_next       = SEQ_TRI_WAITP;
            end
            SEQ_TRI_WAITP:
                if (div_rsp.done)
                    state_next = SEQ_TRI_DIVM;
            SEQ_TRI_DIVM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {20'd0, start_reg};
                div_req.divisor  = period_reg;
                div_req.count    = CNT_MOD;
                state_next       = SEQ_TRI_WAITM;
            end
            SEQ_TRI_WAITM:
                if (div_rsp.done)
                    state_next = SEQ_TRI_MULM;
            SEQ_TRI_MULM:
                state_next = SEQ_SMP_TRI_MUL;
            SEQ_SMP_SIN_MUL:
                state_next = SEQ_SMP_SIN_RND;
            SEQ_SMP_SIN_RND:
                state_next = SEQ_EMIT;
            SEQ_SMP_TRI_MUL:
                state_next = SEQ_SMP_TRI_DIV;
            SEQ_SMP_TRI_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = scale_dividend;
                div_req.divisor  = {fs_eff, 1'b0};
                div_req.count    = CNT_SCALE;
                state_next       = SEQ_SMP_TRI_WAIT;
            end
            SEQ_SMP_TRI_WAIT:
                if (div_rsp.done)
                    state_next = SEQ_EMIT;
            SEQ_EMIT:
            begin
                if (out_free)
                begin
                    if (is_last)
                        state_next = SEQ_IDLE;
                    else if (is_sin)
                        state_next = SEQ_SMP_SIN_MUL;
                    else
                        state_next = SEQ_SMP_TRI_MUL;
                end
            end
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SEQ_IDLE;
        else
            state_reg <= state_next;
    end

    // Control registers of the frame and the output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                k_reg <= '0;
            else if (state_reg == SEQ_EMIT && out_free)
                k_reg <= k_reg + 1'b1;

            if (state_reg == SEQ_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            wave_reg  <= items.wave;
            f_reg     <= (items.freq == '0) ? FREQ_W'(1) : items.freq;
            start_reg <= items.phase_start;
            lv_reg    <= env_rsp.level;
            done_reg  <= env_rsp.done;
        end

        case (state_reg)
            SEQ_SIN_MUL, SEQ_SMP_SIN_MUL, SEQ_SMP_TRI_MUL:
                mul_reg <= prod;
            SEQ_SIN_WAIT0:
                if (div_rsp.done)
                begin
                    q5_reg <= div_rsp.quotient[4:0];
                    r_reg  <= div_rsp.remainder[RATE_W-1:0];
                end
            SEQ_SIN_WAIT1:
                if (div_rsp.done)
                begin
                    qinc_reg <= div_rsp.quotient[4:0];
                    rinc_reg <= div_rsp.remainder[RATE_W-1:0];
                end
            SEQ_TRI_WAITP:
                if (div_rsp.done)
                    period_reg <= {1'b0, div_rsp.quotient[RATE_W-1:0]} + 18'd1;
            SEQ_TRI_WAITM:
                if (div_rsp.done)
                    m_reg <= div_rsp.remainder[17:0];
            SEQ_TRI_MULM:
                mf_reg <= prod[RATE_W-1:0];
            SEQ_SMP_SIN_RND:
                samp_reg <= samp_sin;
            SEQ_SMP_TRI_WAIT:
                if (div_rsp.done)
                    samp_reg <= {~div_rsp.quotient[15], div_rsp.quotient[14:0]};
            SEQ_EMIT:
                if (out_free)
                begin
                    out_sample_reg <= samp_reg;
                    out_last_reg   <= is_last;
                    out_done_reg   <= done_reg;
                    // Advance both phase trackers to the next sample.
                    r_reg  <= r_carry ? RATE_W'(r_sum - {1'b0, fs_eff}) : r_sum[RATE_W-1:0];
                    q5_reg <= q5_reg + qinc_reg + {4'd0, r_carry};
                    if (m_wrap)
                    begin
                        m_reg  <= '0;
                        mf_reg <= '0;
                    end
                    else
                    begin
                        m_reg  <= m_inc;
                        mf_reg <= mf_reg + {2'b00, f_reg};
                    end
                end
            default:
                ;
        endcase
    end

endmodule
